### sv/dbm_pkg.sv
// Package with the shared constants and types of the degree-one base multiplier.
package dbm_pkg;

   localparam int COEFF_W = 16;
   localparam int WORD_W = 2 * COEFF_W;
   localparam int LANES = 4;
   localparam int STAGES = WORD_W;
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   localparam logic [COEFF_W-1:0] MODULUS_RESET = 16'd3329;
   localparam logic [0:0] REG_MODULUS = 1'b0;

   // Lane indexes inside the remainder pipeline.
   localparam int LANE_EE = 0;
   localparam int LANE_OO = 1;
   localparam int LANE_CA = 2;
   localparam int LANE_CB = 3;

   // Sideband that travels along the remainder pipeline.
   typedef struct packed {
      logic               last;
      logic [COEFF_W-1:0] zeta;
   } tag_type;

   typedef logic [LANES-1:0][WORD_W-1:0]  lane_word_type;
   typedef logic [LANES-1:0][COEFF_W-1:0] lane_rem_type;

endpackage

### sv/dbm_if.sv
// Valid/ready channel interfaces for coefficient pair words and product words.
interface dbm_req_if;
   logic                        valid;
   logic                        ready;
   logic [dbm_pkg::COEFF_W-1:0] coeff_a_even;
   logic [dbm_pkg::COEFF_W-1:0] coeff_a_odd;
   logic [dbm_pkg::COEFF_W-1:0] coeff_b_even;
   logic [dbm_pkg::COEFF_W-1:0] coeff_b_odd;
   logic [dbm_pkg::COEFF_W-1:0] twiddle;
   logic                        last_pair_in;

   modport source (output valid, coeff_a_even, coeff_a_odd, coeff_b_even, coeff_b_odd,
                   twiddle, last_pair_in, input ready);
   modport sink (input valid, coeff_a_even, coeff_a_odd, coeff_b_even, coeff_b_odd,
                 twiddle, last_pair_in, output ready);
endinterface

interface dbm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dbm_pkg::COEFF_W-1:0] prod_even;
   logic [dbm_pkg::COEFF_W-1:0] prod_odd;
   logic                        last_pair_out;

   modport source (output valid, prod_even, prod_odd, last_pair_out, input ready);
   modport sink (input valid, prod_even, prod_odd, last_pair_out, output ready);
endinterface

### sv/degree_one_base_multiply_mod_q.sv
// Top level: (a0 + a1 X)(b0 + b1 X) mod (X^2 - zeta, q) as a streaming pipeline.
// One word is accepted every cycle while the skid register is empty.
// The two 32-stage remainder pipelines set the depth.
// The skid register behind the output catches one word while the consumer stalls.
// Synchronous active-high reset clears all valid bits and loads the modulus with 3329.
// No clearing pass is needed after reset.
module degree_one_base_multiply_mod_q (
   input  logic                        clock,
   input  logic                        reset,
   dbm_req_if.sink                     req_chan,
   dbm_rsp_if.source                   rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [dbm_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [dbm_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [dbm_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   localparam int CW = dbm_pkg::COEFF_W;
   localparam int WW = dbm_pkg::WORD_W;

   logic [CW-1:0] modulus_ff;
   logic          pipe_en;
   logic          skid_valid_ff;

   // Configuration register.
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= dbm_pkg::MODULUS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[dbm_pkg::ADDR_W-1] == dbm_pkg::REG_MODULUS) begin
         modulus_ff <= csr_pwdata[CW-1:0];
      end
   end
   assign csr_prdata = (csr_paddr[dbm_pkg::ADDR_W-1] == dbm_pkg::REG_MODULUS) ?
                       {{(dbm_pkg::DATA_W-CW){1'b0}}, modulus_ff} : '0;

   // The whole pipeline advances unless the skid register is holding a word.
   assign pipe_en = !skid_valid_ff;
   assign req_chan.ready = pipe_en;

   // Input register.
   logic          in_valid_ff;
   logic [CW-1:0] a0_ff, a1_ff, b0_ff, b1_ff;
   dbm_pkg::tag_type in_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         in_valid_ff <= req_chan.valid;
      end
      if (pipe_en) begin
         a0_ff <= req_chan.coeff_a_even;
         a1_ff <= req_chan.coeff_a_odd;
         b0_ff <= req_chan.coeff_b_even;
         b1_ff <= req_chan.coeff_b_odd;
         in_tag_ff.zeta <= req_chan.twiddle;
         in_tag_ff.last <= req_chan.last_pair_in;
      end
   end

   // Four partial products.
   logic                   prod_valid_ff;
   dbm_pkg::lane_word_type prod_ff;
   dbm_pkg::tag_type       prod_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         prod_valid_ff <= in_valid_ff;
      end
      if (pipe_en) begin
         prod_ff[dbm_pkg::LANE_EE] <= WW'(a0_ff) * WW'(b0_ff);
         prod_ff[dbm_pkg::LANE_OO] <= WW'(a1_ff) * WW'(b1_ff);
         prod_ff[dbm_pkg::LANE_CA] <= WW'(a0_ff) * WW'(b1_ff);
         prod_ff[dbm_pkg::LANE_CB] <= WW'(a1_ff) * WW'(b0_ff);
         prod_tag_ff <= in_tag_ff;
      end
   end

   // First reduction of all four products.
   logic                  r1_valid;
   dbm_pkg::lane_rem_type r1_rem;
   dbm_pkg::tag_type      r1_tag;
   dbm_reduce u_reduce_first (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .q         (modulus_ff),
      .in_valid  (prod_valid_ff),
      .in_lane   (prod_ff),
      .in_tag    (prod_tag_ff),
      .out_valid (r1_valid),
      .out_rem   (r1_rem),
      .out_tag   (r1_tag)
   );

   // Twist the odd-odd term by zeta; the other residues ride along unchanged.
   logic                   tw_valid_ff;
   dbm_pkg::lane_word_type tw_ff;
   dbm_pkg::tag_type       tw_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         tw_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         tw_valid_ff <= r1_valid;
      end
      if (pipe_en) begin
         tw_ff[dbm_pkg::LANE_EE] <= {{CW{1'b0}}, r1_rem[dbm_pkg::LANE_EE]};
         tw_ff[dbm_pkg::LANE_OO] <= WW'(r1_rem[dbm_pkg::LANE_OO]) * WW'(r1_tag.zeta);
         tw_ff[dbm_pkg::LANE_CA] <= {{CW{1'b0}}, r1_rem[dbm_pkg::LANE_CA]};
         tw_ff[dbm_pkg::LANE_CB] <= {{CW{1'b0}}, r1_rem[dbm_pkg::LANE_CB]};
         tw_tag_ff.last <= r1_tag.last;
         tw_tag_ff.zeta <= '0;
      end
   end

   // Second reduction; residues already below q pass through unchanged.
   logic                  r2_valid;
   dbm_pkg::lane_rem_type r2_rem;
   dbm_pkg::tag_type      r2_tag;
   dbm_reduce u_reduce_second (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .q         (modulus_ff),
      .in_valid  (tw_valid_ff),
      .in_lane   (tw_ff),
      .in_tag    (tw_tag_ff),
      .out_valid (r2_valid),
      .out_rem   (r2_rem),
      .out_tag   (r2_tag)
   );

   // Final modular additions; a zero modulus forces both products to zero.
   logic          sum_valid_ff;
   logic [CW-1:0] sum_even_ff, sum_odd_ff;
   logic          sum_last_ff;
   logic [CW-1:0] sum_even_in, sum_odd_in;
   logic [CW:0]   raw_even, raw_odd;
   always_comb begin
      raw_even = {1'b0, r2_rem[dbm_pkg::LANE_EE]} + {1'b0, r2_rem[dbm_pkg::LANE_OO]};
      raw_odd = {1'b0, r2_rem[dbm_pkg::LANE_CA]} + {1'b0, r2_rem[dbm_pkg::LANE_CB]};
      sum_even_in = (raw_even >= {1'b0, modulus_ff}) ?
                    CW'(raw_even - {1'b0, modulus_ff}) : raw_even[CW-1:0];
      sum_odd_in = (raw_odd >= {1'b0, modulus_ff}) ?
                   CW'(raw_odd - {1'b0, modulus_ff}) : raw_odd[CW-1:0];
      if (modulus_ff == '0) begin
         sum_even_in = '0;
         sum_odd_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         sum_valid_ff <= r2_valid;
      end
      if (pipe_en) begin
         sum_even_ff <= sum_even_in;
         sum_odd_ff <= sum_odd_in;
         sum_last_ff <= r2_tag.last;
      end
   end

   // Output register with a skid word behind it.
   logic          out_valid_ff;
   logic [CW-1:0] out_even_ff, out_odd_ff, skid_even_ff, skid_odd_ff;
   logic          out_last_ff, skid_last_ff;
   logic          out_take;
   logic          incoming;
   assign out_take = out_valid_ff && rsp_chan.ready;
   assign incoming = pipe_en && sum_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_ff <= incoming;
      end else if (incoming) begin
         skid_valid_ff <= 1'b1;
      end
      if (skid_valid_ff) begin
         if (out_take) begin
            out_even_ff <= skid_even_ff;
            out_odd_ff <= skid_odd_ff;
            out_last_ff <= skid_last_ff;
         end
      end else if (!out_valid_ff || out_take) begin
         out_even_ff <= sum_even_ff;
         out_odd_ff <= sum_odd_ff;
         out_last_ff <= sum_last_ff;
      end else begin
         skid_even_ff <= sum_even_ff;
         skid_odd_ff <= sum_odd_ff;
         skid_last_ff <= sum_last_ff;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.prod_even = out_even_ff;
   assign rsp_chan.prod_odd = out_odd_ff;
   assign rsp_chan.last_pair_out = out_last_ff;

endmodule

### sv/dbm_reduce.sv
// Pipelined restoring remainder of four 32-bit lanes by the modulus, one bit per stage.
module dbm_reduce (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic [dbm_pkg::COEFF_W-1:0] q,
   input  logic                        in_valid,
   input  dbm_pkg::lane_word_type      in_lane,
   input  dbm_pkg::tag_type            in_tag,
   output logic                        out_valid,
   output dbm_pkg::lane_rem_type       out_rem,
   output dbm_pkg::tag_type            out_tag
);

   logic                  valid_ff [dbm_pkg::STAGES];
   dbm_pkg::lane_rem_type rem_ff   [dbm_pkg::STAGES];
   dbm_pkg::lane_rem_type rem_in   [dbm_pkg::STAGES];
   dbm_pkg::lane_word_type word_ff [dbm_pkg::STAGES];
   dbm_pkg::tag_type      tag_ff   [dbm_pkg::STAGES];

   // Each stage shifts in one dividend bit and subtracts q when it fits.
   always_comb begin
      logic [dbm_pkg::COEFF_W:0]   shifted;
      logic [dbm_pkg::COEFF_W-1:0] prev;
      logic                        bit_in;
      for (int s = 0; s < dbm_pkg::STAGES; s++) begin
         for (int l = 0; l < dbm_pkg::LANES; l++) begin
            if (s == 0) begin
               prev = '0;
               bit_in = in_lane[l][dbm_pkg::WORD_W-1];
            end else begin
               prev = rem_ff[(s == 0) ? 0 : s - 1][l];
               bit_in = word_ff[(s == 0) ? 0 : s - 1][l][dbm_pkg::WORD_W-1-s];
            end
            shifted = {prev, bit_in};
            if (shifted >= {1'b0, q}) begin
               rem_in[s][l] = dbm_pkg::COEFF_W'(shifted - {1'b0, q});
            end else begin
               rem_in[s][l] = shifted[dbm_pkg::COEFF_W-1:0];
            end
         end
      end
   end

   // Stage registers move together whenever the pipeline is enabled.
   always_ff @(posedge clock) begin
      for (int s = 0; s < dbm_pkg::STAGES; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= (s == 0) ? in_valid : valid_ff[(s == 0) ? 0 : s - 1];
         end
         if (en) begin
            rem_ff[s] <= rem_in[s];
            word_ff[s] <= (s == 0) ? in_lane : word_ff[(s == 0) ? 0 : s - 1];
            tag_ff[s] <= (s == 0) ? in_tag : tag_ff[(s == 0) ? 0 : s - 1];
         end
      end
   end

   assign out_valid = valid_ff[dbm_pkg::STAGES-1];
   assign out_rem = rem_ff[dbm_pkg::STAGES-1];
   assign out_tag = tag_ff[dbm_pkg::STAGES-1];

endmodule

### tb/degree_one_base_multiply_mod_q_tb.sv
// Testbench for the degree-one base multiplier: predicts each product word and checks it.
module degree_one_base_multiply_mod_q_tb;

   typedef struct packed {
      logic [dbm_pkg::COEFF_W-1:0] a_even;
      logic [dbm_pkg::COEFF_W-1:0] a_odd;
      logic [dbm_pkg::COEFF_W-1:0] b_even;
      logic [dbm_pkg::COEFF_W-1:0] b_odd;
      logic [dbm_pkg::COEFF_W-1:0] zeta;
      logic                        last;
   } pair_word_type;

   typedef struct packed {
      logic [dbm_pkg::COEFF_W-1:0] c_even;
      logic [dbm_pkg::COEFF_W-1:0] c_odd;
      logic                        last;
   } product_word_type;

   localparam logic [dbm_pkg::ADDR_W-1:0] MODULUS_ADDR =
      dbm_pkg::ADDR_W'(4 * dbm_pkg::REG_MODULUS);
   localparam logic [dbm_pkg::ADDR_W-1:0] UNUSED_ADDR = 3'd4;
   localparam int LATENCY = 68;
   localparam int STALL_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [dbm_pkg::ADDR_W-1:0] csr_paddr = '0;
   logic [dbm_pkg::DATA_W-1:0] csr_pwdata = '0;
   logic [dbm_pkg::DATA_W-1:0] csr_prdata;
   logic csr_pready;

   dbm_req_if req_chan();
   dbm_rsp_if rsp_chan();

   degree_one_base_multiply_mod_q i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [dbm_pkg::COEFF_W-1:0] modulus_q = dbm_pkg::MODULUS_RESET;
   pair_word_type pending_pairs[$];
   product_word_type expected_products[$];
   int error_count = 0;
   int idle_cycles = 0;
   bit driver_enable = 1'b0;
   bit timed_out = 1'b0;

   // Product of two degree-one polynomials modulo X^2 - zeta and q.
   function automatic product_word_type pair_product(pair_word_type p,
                                                     logic [dbm_pkg::COEFF_W-1:0] q);
      product_word_type r;
      logic [63:0] qq, ee, oo, tw, ca, cb;
      qq = 64'(q);
      r.last = p.last;
      r.c_even = '0;
      r.c_odd = '0;
      if (qq != 0) begin
         ee = (64'(p.a_even) * 64'(p.b_even)) % qq;
         oo = (64'(p.a_odd) * 64'(p.b_odd)) % qq;
         tw = (oo * 64'(p.zeta)) % qq;
         ca = (64'(p.a_even) * 64'(p.b_odd)) % qq;
         cb = (64'(p.a_odd) * 64'(p.b_even)) % qq;
         r.c_even = dbm_pkg::COEFF_W'((ee + tw) % qq);
         r.c_odd = dbm_pkg::COEFF_W'((ca + cb) % qq);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   // Driver: presents pending pair words with a random gap after each accepted one.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.coeff_a_even <= '0;
         req_chan.coeff_a_odd <= '0;
         req_chan.coeff_b_even <= '0;
         req_chan.coeff_b_odd <= '0;
         req_chan.twiddle <= '0;
         req_chan.last_pair_in <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_products.push_back(pair_product(pending_pairs.pop_front(), modulus_q));
            send_gap = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) send_gap = 0;
         end
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (driver_enable && pending_pairs.size() > 0 && send_gap == 0) begin
               req_chan.valid <= 1'b1;
               {req_chan.coeff_a_even, req_chan.coeff_a_odd, req_chan.coeff_b_even,
                req_chan.coeff_b_odd, req_chan.twiddle, req_chan.last_pair_in} <= pending_pairs[0];
            end else begin
               req_chan.valid <= 1'b0;
               if (send_gap > 0) send_gap--;
            end
         end
      end
   end

   // Monitor: stalls at random and checks each product word against the oldest prediction.
   int stall = 0;
   always @(posedge clock) begin
      product_word_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_products.size() == 0) begin
               report_mismatch("unexpected word", 0, 0);
            end else begin
               want = expected_products.pop_front();
               if (rsp_chan.prod_even !== want.c_even)
                  report_mismatch("prod_even", rsp_chan.prod_even, want.c_even);
               if (rsp_chan.prod_odd !== want.c_odd)
                  report_mismatch("prod_odd", rsp_chan.prod_odd, want.c_odd);
               if (rsp_chan.last_pair_out !== want.last)
                  report_mismatch("last_pair_out", rsp_chan.last_pair_out, want.last);
            end
            stall = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) stall = 0;
         end
         if (stall > 0) begin
            stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("Some tests failed");
         $finish;
      end
   end

   // One APB write: setup cycle then access cycle, then a check of csr_pready and, for the modulus, of csr_prdata.
   task automatic csr_write(logic [dbm_pkg::ADDR_W-1:0] addr,
                            logic [dbm_pkg::DATA_W-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == MODULUS_ADDR) modulus_q = data[dbm_pkg::COEFF_W-1:0];
      @(posedge clock);
      if (csr_pready !== 1'b1)
         report_mismatch("csr_pready", csr_pready, 1);
      if (addr == MODULUS_ADDR &&
          csr_prdata !== {{(dbm_pkg::DATA_W-dbm_pkg::COEFF_W){1'b0}}, modulus_q})
         report_mismatch("csr_prdata", csr_prdata, modulus_q);
   endtask

   function automatic pair_word_type random_pair(logic [dbm_pkg::COEFF_W-1:0] q);
      pair_word_type p;
      int unsigned top;
      // Mostly reduced operands, sometimes the full field range.
      top = (q != 0 && $urandom_range(0, 3) != 0) ? q - 1 : 16'hFFFF;
      p.a_even = dbm_pkg::COEFF_W'($urandom_range(0, top));
      p.a_odd = dbm_pkg::COEFF_W'($urandom_range(0, top));
      p.b_even = dbm_pkg::COEFF_W'($urandom_range(0, top));
      p.b_odd = dbm_pkg::COEFF_W'($urandom_range(0, top));
      p.zeta = dbm_pkg::COEFF_W'($urandom_range(0, top));
      p.last = ($urandom_range(0, 7) == 0);
      return p;
   endfunction

   // Lets the pipeline drain before touching the modulus.
   task automatic wait_drained();
      driver_enable = 1'b0;
      while (pending_pairs.size() > 0 || expected_products.size() > 0 || req_chan.valid)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic run_phase(int count);
      repeat (count) pending_pairs.push_back(random_pair(modulus_q));
      driver_enable = 1'b1;
      while (pending_pairs.size() > 0) @(posedge clock);
      wait_drained();
   endtask

   initial begin
      logic [dbm_pkg::COEFF_W-1:0] moduli[8];
      pair_word_type p;
      logic [dbm_pkg::COEFF_W-1:0] ext[4];
      moduli = '{16'd3329, 16'd65535, 16'd2, 16'd1, 16'd0, 16'd7681, 16'd65521, 16'd12289};
      ext = '{16'd0, 16'd1, 16'd3328, 16'hFFFF};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at reset modulus: field extremes and unreduced inputs.
      for (int i = 0; i < 20; i++) begin
         p.a_even = ext[i % 4];
         p.a_odd = ext[(i / 4) % 4];
         p.b_even = ext[(i + 1) % 4];
         p.b_odd = ext[(i + 3) % 4];
         p.zeta = ext[(i + 2) % 4];
         p.last = i[0];
         pending_pairs.push_back(p);
      end
      driver_enable = 1'b1;
      while (pending_pairs.size() > 0) @(posedge clock);
      wait_drained();

      // A write to an unused address must not change the modulus.
      csr_write(UNUSED_ADDR, 32'd17);
      p = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
      pending_pairs.push_back(p);
      run_phase(20);

      // Random phases across several moduli, extremes included.
      foreach (moduli[i]) begin
         csr_write(MODULUS_ADDR, {16'($urandom_range(0, 16'hFFFF)), moduli[i]});
         modulus_q = moduli[i];
         pending_pairs.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
         run_phase(moduli[i] < 3 ? 40 : 100);
      end
      csr_write(MODULUS_ADDR, 32'(16'hABCD ^ 16'($urandom_range(0, 16'hFFFF))));
      run_phase(40);

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### filelist.f
sv/dbm_pkg.sv
sv/dbm_if.sv
sv/dbm_reduce.sv
sv/degree_one_base_multiply_mod_q.sv
tb/degree_one_base_multiply_mod_q_tb.sv
